@@ design/odst_pkg.sv @@
package odst_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 24;
    localparam int VAL_W   = 32;

    localparam int RIGHT_READ  = 0;
    localparam int RIGHT_WRITE = 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] val_t;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_FORCE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_FOUND     = 2'd1,
        ST_NOT_PERMITTED = 2'd2,
        ST_FULL          = 2'd3
    } status_t;

    typedef struct packed {
        key_t       key;
        logic [1:0] rights;
        val_t       value;
    } entry_t;

    typedef struct packed {
        action_t    action;
        key_t       key;
        logic [1:0] rights;
        val_t       wval;
    } item_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        idx_t   raddr;
    } mem_req_t;

    typedef struct packed {
        status_t status;
        val_t    value;
    } res_t;

endpackage

@@ design/object_dictionary_search_table.sv @@
// key/value table with binary search over ascending keys
// input channel: in_valid/in_ready carrying action, index, subindex,
//   access_rights and write_value; one transfer is one action
// output channel: out_valid/out_ready carrying status and read_value;
//   every input transfer gives exactly one output transfer, in order
// add goes straight from idle to the done state, from which its result is
//   loaded into the output register once that register is free
// read and both writes reach the done state after p probes of the entry
//   memory in the probe and check states (p is zero for an empty table and
//   at most log2(ENTRIES)+1), and load the output register from there;
//   each probe is one read of the entry memory, whose data returns in the
//   next cycle and decides the next probe address
// one action is worked at a time; in_ready is high only while idle, so the
//   next input transfer waits until the done state hands its result on
// the result sits in an output register, so the next action can be taken
//   while that result waits; a stalled receiver only holds the engine once
//   a second result is ready
// reset clears the entry count, so the table is empty; entry storage is
//   not cleared and needs no clearing pass
module object_dictionary_search_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] index,
    input  logic [7:0]  subindex,
    input  logic [1:0]  access_rights,
    input  logic [31:0] write_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] read_value
);
    import odst_pkg::*;

    item_t    item;
    mem_req_t req;
    entry_t   rdata;
    res_t     res;
    logic     res_valid;
    logic     res_take;

    logic     out_valid_reg;
    status_t  status_reg;
    val_t     read_value_reg;

    assign item.action = action_t'(action);
    assign item.key    = {index, subindex};
    assign item.rights = access_rights;
    assign item.wval   = write_value;

    odst_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item),
        .req       (req),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    odst_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            status_reg     <= res.status;
            read_value_reg <= res.value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;

endmodule

@@ design/odst_store.sv @@
module odst_store (
    input  logic              clk,
    input  odst_pkg::mem_req_t req,
    output odst_pkg::entry_t   rdata
);
    import odst_pkg::*;

    entry_t entry_mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entry_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= entry_mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/odst_search.sv @@
module odst_search (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  odst_pkg::item_t    item,
    output odst_pkg::mem_req_t req,
    input  odst_pkg::entry_t   rdata,
    output logic              res_valid,
    input  logic              res_take,
    output odst_pkg::res_t     res
);
    import odst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    action_t act_reg, act_next;
    key_t    key_reg, key_next;
    val_t    wval_reg, wval_next;
    cnt_t    lo_reg, lo_next;
    cnt_t    hi_reg, hi_next;
    idx_t    mid_reg, mid_next;
    cnt_t    count_reg, count_next;
    status_t status_reg, status_next;
    val_t    value_reg, value_next;

    cnt_t    lo_cmp, hi_cmp, mid_cmp;

    // hi is exclusive here: the search range is lo .. hi-1
    function automatic cnt_t mid_of(input cnt_t lo, input cnt_t hi);
        cnt_t span;
        span = hi - lo - cnt_t'(1);
        return lo + (span >> 1);
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        wval_next   = wval_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        count_next  = count_reg;
        status_next = status_reg;
        value_next  = value_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        req         = '0;
        lo_cmp      = lo_reg;
        hi_cmp      = hi_reg;
        mid_cmp     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    act_next   = item.action;
                    key_next   = item.key;
                    wval_next  = item.wval;
                    value_next = '0;
                    if (item.action == ACT_ADD)
                    begin
                        if (count_reg == cnt_t'(ENTRIES))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            req.we      = 1'b1;
                            req.waddr   = count_reg[IDX_W-1:0];
                            req.wdata   = '{key: item.key, rights: item.rights, value: '0};
                            count_next  = count_reg + cnt_t'(1);
                            status_next = ST_OK;
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                mid_cmp    = mid_of(lo_reg, hi_reg);
                req.raddr  = mid_cmp[IDX_W-1:0];
                mid_next   = mid_cmp[IDX_W-1:0];
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (rdata.key == key_reg)
                begin
                    status_next = ST_OK;
                    unique case (act_reg)
                        ACT_READ:
                        begin
                            if (rdata.rights[RIGHT_READ])
                            begin
                                value_next = rdata.value;
                            end
                            else
                            begin
                                status_next = ST_NOT_PERMITTED;
                            end
                        end
                        ACT_WRITE:
                        begin
                            if (rdata.rights[RIGHT_WRITE])
                            begin
                                req.we    = 1'b1;
                                req.waddr = mid_reg;
                                req.wdata = '{key: rdata.key, rights: rdata.rights,
                                              value: wval_reg};
                            end
                            else
                            begin
                                status_next = ST_NOT_PERMITTED;
                            end
                        end
                        ACT_FORCE:
                        begin
                            req.we    = 1'b1;
                            req.waddr = mid_reg;
                            req.wdata = '{key: rdata.key, rights: rdata.rights,
                                          value: wval_reg};
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    state_next = S_DONE;
                end
                else
                begin
                    if (rdata.key < key_reg)
                    begin
                        lo_cmp = {1'b0, mid_reg} + cnt_t'(1);
                    end
                    else
                    begin
                        hi_cmp = {1'b0, mid_reg};
                    end
                    if (lo_cmp < hi_cmp)
                    begin
                        // next probe issued straight away, data back next cycle
                        mid_cmp   = mid_of(lo_cmp, hi_cmp);
                        req.raddr = mid_cmp[IDX_W-1:0];
                        mid_next  = mid_cmp[IDX_W-1:0];
                        lo_next   = lo_cmp;
                        hi_next   = hi_cmp;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= ACT_ADD;
            key_reg    <= '0;
            wval_reg   <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            count_reg  <= '0;
            status_reg <= ST_OK;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            key_reg    <= key_next;
            wval_reg   <= wval_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            mid_reg    <= mid_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    assign res.status = status_reg;
    assign res.value  = value_reg;

endmodule

@@ design/odst_checker.sv @@
module odst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] read_value
);
    import odst_pkg::*;

    // a stalled result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value))
        else $error("result changed while stalled");

    // only a successful read carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == '0)
        else $error("read value not zero on a failed action");

    // one action at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an action is in flight");

    // a new result comes only from an action in flight
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared with no action in flight");

endmodule

bind object_dictionary_search_table odst_checker u_odst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .read_value    (read_value)
);
